[hw/rtl/ltp_pkg.sv]
`default_nettype none
package ltp_pkg;
	localparam int Depth = 16;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_TOUCH = 3'd1,
		FN_EVICT = 3'd2,
		FN_REMOVE_W = 3'd3,
		FN_LOOKUP = 3'd4,
		FN_STATS = 3'd5,
		FN_CLEAR = 3'd6,
		FN_NOP = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOCFG = 3'd1,
		ST_EXISTS = 3'd2,
		ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_IO = 3'd5
	} status_t;

	// Request from the sequencer to the scan unit, and its answer.
	typedef struct packed {
		logic start;
		logic mode_old;
		logic [63:0] key;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic found;
		logic [IdxW-1:0] pos;
	} scan_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/ltp_scan.sv]
`default_nettype none
// Shared compare unit: walks the recency list one position per cycle. In key mode it
// searches from the front for a matching key; in oldest mode it searches from the
// back for the first read entry.
module ltp_scan import ltp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire scan_req_t req,
	input wire logic [CntW-1:0] occ,
	input wire logic [63:0] cur_key,
	input wire logic cur_pinned,
	output logic [IdxW-1:0] pos,
	output scan_rsp_t rsp
);
	logic busy_q, mode_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] pos_q;
	logic [63:0] key_q;
	logic match;

	assign pos = pos_q;
	assign match = mode_q ? !cur_pinned : (cur_key == key_q);

	// One position is compared per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp <= '0;
			mode_q <= 1'b0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				mode_q <= req.mode_old;
				key_q <= req.key;
				cnt_q <= occ;
				pos_q <= req.mode_old ? IdxW'(occ - CntW'(1)) : '0;
				busy_q <= (occ != '0);
				if (occ == '0) begin
					rsp.done <= 1'b1;
					rsp.found <= 1'b0;
				end
			end else if (busy_q) begin
				if (match || cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					rsp.done <= 1'b1;
					rsp.found <= match;
					rsp.pos <= pos_q;
				end else begin
					cnt_q <= cnt_q - CntW'(1);
					pos_q <= mode_q ? pos_q - IdxW'(1) : pos_q + IdxW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/lru_table_with_pinned_entries_unit.sv]
`default_nettype none
// LRU table of up to sixteen 64-bit keys, each read (evictable) or write (pinned),
// kept in recency order. One word is taken at a time; stall stays high until its
// result has been taken. A key or victim search walks the recency list one position
// per cycle through one shared compare unit, and a list shift moves one position per
// cycle each way. The longest case is an insert into a full table whose only read
// entry is the most recent one. No clearing pass is needed after reset.
module lru_table_with_pinned_entries_unit import ltp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] func,
	input wire logic [63:0] volume_key,
	input wire logic is_write,
	input wire logic move_ok,
	input wire logic disposal_ok,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic hit,
	output logic evicted_valid,
	output logic [63:0] evicted_key,
	output logic [4:0] used_count,
	output logic [4:0] read_entries,
	output logic [4:0] write_entries,
	output logic [4:0] free_count
);
	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_FINDW, S_OLD, S_OLDW, S_REMOVE, S_SHL, S_PUSH, S_SHR,
		S_CLEAR, S_DONE, S_OUT
	} state_t;

	state_t state_q;
	logic [63:0] slot_key_q [Depth];
	logic [Depth-1:0] valid_q, pinned_q;
	logic [IdxW-1:0] list_q [Depth];
	logic [CntW-1:0] occ_q, rd_q, wr_q;
	logic [4:0] cap_q;
	func_t fn_q;
	logic [63:0] key_q;
	logic isw_q, mov_q, disp_q, pin_new_q;
	logic [IdxW-1:0] i_q, stop_q, hold_q, fslot;
	logic [CntW-1:0] eff_cap;
	scan_req_t req;
	scan_rsp_t rsp;
	logic [IdxW-1:0] spos, sslot;

	assign sslot = list_q[spos];
	ltp_scan u_scan (.clk, .arst_n, .req, .occ(occ_q), .cur_key(slot_key_q[sslot]),
		.cur_pinned(pinned_q[sslot]), .pos(spos), .rsp);

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign eff_cap = (cap_q > 5'(Depth)) ? CntW'(Depth) : CntW'(cap_q);

	// Lowest free slot.
	always_comb begin
		fslot = '0;
		for (int s = Depth - 1; s >= 0; s--) begin
			if (!valid_q[s]) fslot = IdxW'(s);
		end
	end

	always_comb begin
		req.start = (state_q == S_FIND) || (state_q == S_OLD);
		req.mode_old = (state_q == S_OLD);
		req.key = key_q;
	end

	// Operation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			occ_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			cap_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fn_q <= func_t'(func);
						key_q <= volume_key;
						isw_q <= is_write;
						mov_q <= move_ok;
						disp_q <= disposal_ok;
						status <= ST_OK;
						hit <= 1'b0;
						evicted_valid <= 1'b0;
						evicted_key <= '0;
						case (func_t'(func))
							FN_INSERT: begin
								if (cap_q == '0) begin
									status <= ST_NOCFG;
									state_q <= S_DONE;
								end else state_q <= S_FIND;
							end
							FN_TOUCH, FN_REMOVE_W, FN_LOOKUP: state_q <= S_FIND;
							FN_EVICT: state_q <= S_OLD;
							FN_CLEAR: state_q <= S_CLEAR;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FIND: state_q <= S_FINDW;
				S_OLD: state_q <= S_OLDW;
				S_FINDW: begin
					if (rsp.done) begin
						i_q <= rsp.pos;
						case (fn_q)
							FN_INSERT: begin
								if (rsp.found) begin
									status <= ST_EXISTS;
									state_q <= S_DONE;
								end else if (occ_q >= eff_cap) state_q <= S_OLD;
								else if (!mov_q) begin
									status <= ST_IO;
									state_q <= S_DONE;
								end else begin
									pin_new_q <= isw_q;
									state_q <= S_PUSH;
								end
							end
							FN_TOUCH: begin
								if (rsp.found) begin
									hold_q <= list_q[rsp.pos];
									state_q <= S_SHR;
								end else state_q <= S_DONE;
							end
							FN_REMOVE_W: begin
								if (rsp.found && pinned_q[list_q[rsp.pos]]) state_q <= S_REMOVE;
								else begin
									status <= ST_NOTFOUND;
									state_q <= S_DONE;
								end
							end
							default: begin
								hit <= rsp.found;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_OLDW: begin
					if (rsp.done) begin
						i_q <= rsp.pos;
						if (rsp.found) state_q <= S_REMOVE;
						else begin
							status <= (fn_q == FN_INSERT) ? ST_FULL : ST_NOTFOUND;
							state_q <= S_DONE;
						end
					end
				end
				// Drop the entry at list position i_q, then close the gap.
				S_REMOVE: begin
					valid_q[list_q[i_q]] <= 1'b0;
					if (pinned_q[list_q[i_q]]) wr_q <= wr_q - CntW'(1);
					else rd_q <= rd_q - CntW'(1);
					evicted_valid <= 1'b1;
					evicted_key <= slot_key_q[list_q[i_q]];
					hold_q <= list_q[i_q];
					occ_q <= occ_q - CntW'(1);
					stop_q <= IdxW'(occ_q - CntW'(1));
					state_q <= S_SHL;
				end
				S_SHL: begin
					if (CntW'(i_q) + CntW'(1) < CntW'(stop_q) + CntW'(1) && i_q != stop_q) begin
						list_q[i_q] <= list_q[i_q + IdxW'(1)];
						i_q <= i_q + IdxW'(1);
					end else if (fn_q != FN_INSERT) begin
						if (!disp_q) status <= ST_IO;
						state_q <= S_DONE;
					end else if (!disp_q) begin
						status <= ST_IO;
						state_q <= S_DONE;
					end else if (!mov_q) begin
						// Victim goes back to the front as a read entry.
						status <= ST_IO;
						key_q <= evicted_key;
						pin_new_q <= 1'b0;
						evicted_valid <= 1'b0;
						evicted_key <= '0;
						state_q <= S_PUSH;
					end else begin
						pin_new_q <= isw_q;
						state_q <= S_PUSH;
					end
				end
				// Claim a slot, then shift the list right to open the front.
				S_PUSH: begin
					if (occ_q < CntW'(Depth)) begin
						valid_q[fslot] <= 1'b1;
						slot_key_q[fslot] <= key_q;
						pinned_q[fslot] <= pin_new_q;
						if (pin_new_q) wr_q <= wr_q + CntW'(1);
						else rd_q <= rd_q + CntW'(1);
						hold_q <= fslot;
						i_q <= IdxW'(occ_q);
						occ_q <= occ_q + CntW'(1);
						state_q <= S_SHR;
					end else state_q <= S_DONE;
				end
				S_SHR: begin
					if (i_q != '0) begin
						list_q[i_q] <= list_q[i_q - IdxW'(1)];
						i_q <= i_q - IdxW'(1);
					end else begin
						list_q[0] <= hold_q;
						state_q <= S_DONE;
					end
				end
				S_CLEAR: begin
					valid_q <= '0;
					occ_q <= '0;
					rd_q <= '0;
					wr_q <= '0;
					cap_q <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					used_count <= occ_q;
					read_entries <= rd_q;
					write_entries <= wr_q;
					free_count <= (cap_q > occ_q) ? cap_q - occ_q : '0;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ltp_checker.sv]
`default_nettype none
module ltp_checker import ltp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [2:0] status,
	input wire logic hit,
	input wire logic evicted_valid,
	input wire logic [63:0] evicted_key,
	input wire logic [4:0] used_count,
	input wire logic [4:0] read_entries,
	input wire logic [4:0] write_entries
);
	// A result holds while it is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(evicted_key))
		else $error("result changed under stall");
	// Counts add up.
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count == read_entries + write_entries)
		else $error("counts inconsistent");
	// No word is taken while a result is shown.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during result");
	// Key is zero when nothing was evicted.
	a_ekey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_key == '0 && used_count <= 5'(Depth))
		else $error("stale evicted key");
	// A lookup hit never removes anything.
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == ST_OK && !evicted_valid)
		else $error("hit with removal or error");
endmodule

bind lru_table_with_pinned_entries_unit ltp_checker u_chk (.clk, .arst_n,
	.in_stall, .out_valid, .out_stall, .status, .hit, .evicted_valid, .evicted_key,
	.used_count, .read_entries, .write_entries);
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
	import ltp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;
	localparam int SettleCycles = 60;

	typedef struct {
		status_t status;
		logic hit;
		logic evicted_valid;
		logic [63:0] evicted_key;
		logic [4:0] used_count;
		logic [4:0] read_entries;
		logic [4:0] write_entries;
		logic [4:0] free_count;
	} table_result_t;

	// Mirror of the table: slot contents, recency order and capacity.
	class table_scoreboard;
		logic [63:0] slot_key[Depth];
		bit slot_used[Depth];
		bit slot_pin[Depth];
		int order[Depth];
		int occ;
		int cap;
		table_result_t pending_results[$];
		int mismatches;

		function new();
			occ = 0;
			cap = 0;
			mismatches = 0;
			foreach (slot_used[i]) begin
				slot_used[i] = 0;
				slot_pin[i] = 0;
				slot_key[i] = '0;
				order[i] = 0;
			end
		endfunction

		function void set_capacity(logic [4:0] v);
			cap = int'(v);
		endfunction

		function int key_pos(logic [63:0] k);
			for (int p = 0; p < occ; p++)
				if (slot_used[order[p]] && slot_key[order[p]] == k)
					return p;
			return -1;
		endfunction

		function int oldest_read_pos();
			for (int p = occ - 1; p >= 0; p--)
				if (slot_used[order[p]] && !slot_pin[order[p]])
					return p;
			return -1;
		endfunction

		function logic [63:0] take_out(int p);
			int s;
			s = order[p];
			slot_used[s] = 0;
			for (int i = p; i + 1 < occ; i++)
				order[i] = order[i + 1];
			if (occ > 0)
				occ--;
			return slot_key[s];
		endfunction

		function void add_front(logic [63:0] k, bit pin);
			int s;
			if (occ >= Depth)
				return;
			s = -1;
			for (int i = Depth - 1; i >= 0; i--)
				if (!slot_used[i])
					s = i;
			if (s < 0)
				return;
			slot_used[s] = 1;
			slot_key[s] = k;
			slot_pin[s] = pin;
			for (int i = occ; i > 0; i--)
				order[i] = order[i - 1];
			order[0] = s;
			occ++;
		endfunction

		// Works out the answer to one accepted word and queues it.
		function void note_word(func_t fn, logic [63:0] k, bit wr, bit mv_ok, bit disp_ok);
			table_result_t r;
			int p, eff, rd, wc, sl;
			r.status = ST_OK;
			r.hit = 0;
			r.evicted_valid = 0;
			r.evicted_key = '0;
			case (fn)
				FN_INSERT: begin
					eff = (cap > Depth) ? Depth : cap;
					if (cap == 0)
						r.status = ST_NOCFG;
					else if (key_pos(k) >= 0)
						r.status = ST_EXISTS;
					else begin
						p = 0;
						if (occ >= eff) begin
							p = oldest_read_pos();
							if (p < 0)
								r.status = ST_FULL;
							else begin
								r.evicted_key = take_out(p);
								r.evicted_valid = 1;
								if (!disp_ok)
									r.status = ST_IO;
							end
						end
						if (r.status == ST_OK) begin
							if (!mv_ok) begin
								// The victim goes back at the front when the move fails.
								if (r.evicted_valid) begin
									add_front(r.evicted_key, 0);
									r.evicted_valid = 0;
									r.evicted_key = '0;
								end
								r.status = ST_IO;
							end else
								add_front(k, wr);
						end
					end
				end
				FN_TOUCH: begin
					p = key_pos(k);
					if (p >= 0) begin
						sl = order[p];
						for (int i = p; i > 0; i--)
							order[i] = order[i - 1];
						order[0] = sl;
					end
				end
				FN_EVICT: begin
					p = oldest_read_pos();
					if (p < 0)
						r.status = ST_NOTFOUND;
					else begin
						r.evicted_key = take_out(p);
						r.evicted_valid = 1;
						r.status = disp_ok ? ST_OK : ST_IO;
					end
				end
				FN_REMOVE_W: begin
					p = key_pos(k);
					if (p < 0 || !slot_pin[order[p]])
						r.status = ST_NOTFOUND;
					else begin
						r.evicted_key = take_out(p);
						r.evicted_valid = 1;
						r.status = disp_ok ? ST_OK : ST_IO;
					end
				end
				FN_LOOKUP: r.hit = (key_pos(k) >= 0);
				FN_CLEAR: begin
					foreach (slot_used[i])
						slot_used[i] = 0;
					occ = 0;
					cap = 0;
				end
				default: ;
			endcase
			rd = 0;
			wc = 0;
			foreach (slot_used[i])
				if (slot_used[i]) begin
					if (slot_pin[i])
						wc++;
					else
						rd++;
				end
			r.used_count = 5'(occ);
			r.read_entries = 5'(rd);
			r.write_entries = 5'(wc);
			r.free_count = 5'((cap > occ) ? cap - occ : 0);
			pending_results = {pending_results, r};
		endfunction

		// Compares one accepted answer with the oldest expectation.
		function void check_answer(table_result_t got);
			table_result_t exp_r;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer: status %0d", got.status);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.status !== exp_r.status || got.hit !== exp_r.hit
			    || got.evicted_valid !== exp_r.evicted_valid
			    || got.evicted_key !== exp_r.evicted_key
			    || got.used_count !== exp_r.used_count
			    || got.read_entries !== exp_r.read_entries
			    || got.write_entries !== exp_r.write_entries
			    || got.free_count !== exp_r.free_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st%0d h%0d ev%0d k%h u%0d r%0d w%0d f%0d",
						exp_r.status, exp_r.hit, exp_r.evicted_valid, exp_r.evicted_key,
						exp_r.used_count, exp_r.read_entries, exp_r.write_entries,
						exp_r.free_count,
						" / got st%0d h%0d ev%0d k%h u%0d r%0d w%0d f%0d",
						got.status, got.hit, got.evicted_valid,
						got.evicted_key, got.used_count, got.read_entries,
						got.write_entries, got.free_count);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [4:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] func = '0;
	logic [63:0] volume_key = '0;
	logic is_write = 0;
	logic move_ok = 0;
	logic disposal_ok = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic hit;
	logic evicted_valid;
	logic [63:0] evicted_key;
	logic [4:0] used_count, read_entries, write_entries, free_count;

	table_scoreboard sb = new();
	bit quiet = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic [63:0] key_pool[24];

	lru_table_with_pinned_entries_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.volume_key(volume_key), .is_write(is_write), .move_ok(move_ok),
		.disposal_ok(disposal_ok), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .evicted_valid(evicted_valid),
		.evicted_key(evicted_key), .used_count(used_count),
		.read_entries(read_entries), .write_entries(write_entries),
		.free_count(free_count)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Answer side: check each accepted answer.
	always @(posedge clk) begin
		table_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status_t'(status);
			got.hit = hit;
			got.evicted_valid = evicted_valid;
			got.evicted_key = evicted_key;
			got.used_count = used_count;
			got.read_entries = read_entries;
			got.write_entries = write_entries;
			got.free_count = free_count;
			sb.check_answer(got);
		end
	end

	// Receiver stalls in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_stall <= 1;
		end else
			out_stall <= 0;
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Presents one word and holds it until it is taken.
	task automatic send_word(func_t fn, logic [63:0] k, bit wr, bit mv_ok, bit disp_ok);
		func <= fn;
		volume_key <= k;
		is_write <= wr;
		move_ok <= mv_ok;
		disposal_ok <= disp_ok;
		in_valid <= 1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_word(fn, k, wr, mv_ok, disp_ok);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_answers();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending_results.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_capacity(v);
	endtask

	function automatic func_t pick_func();
		int r;
		r = $urandom_range(0, 199);
		if (r < 80) return FN_INSERT;
		if (r < 104) return FN_TOUCH;
		if (r < 124) return FN_EVICT;
		if (r < 144) return FN_REMOVE_W;
		if (r < 176) return FN_LOOKUP;
		if (r < 186) return FN_STATS;
		if (r < 189) return FN_CLEAR;
		return FN_NOP;
	endfunction

	initial begin
		int caps[12] = '{16, 1, 31, 2, 17, 4, 8, 0, 16, 3, 12, 6};
		logic [63:0] k;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: unset capacity, duplicates, full table, failed
		// disposal and failed move, pinned entries and clear.
		send_word(FN_INSERT, '1, 1'b0, 1'b1, 1'b1);
		send_word(FN_NOP, '0, 1'b0, 1'b1, 1'b1);
		drain_answers();
		write_capacity(5'd2);
		send_word(FN_INSERT, '1, 1'b0, 1'b1, 1'b1);
		send_word(FN_INSERT, '0, 1'b1, 1'b1, 1'b1);
		send_word(FN_INSERT, '1, 1'b1, 1'b1, 1'b1);
		send_word(FN_INSERT, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b1, 1'b0);
		send_word(FN_INSERT, 64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 1'b1);
		send_word(FN_INSERT, 64'h1234, 1'b1, 1'b1, 1'b1);
		send_word(FN_INSERT, 64'h1234_5678, 1'b0, 1'b0, 1'b1);
		send_word(FN_INSERT, 64'h77, 1'b0, 1'b1, 1'b1);
		send_word(FN_TOUCH, 64'h99, 1'b0, 1'b1, 1'b1);
		send_word(FN_TOUCH, '0, 1'b0, 1'b1, 1'b1);
		send_word(FN_LOOKUP, 64'h1234, 1'b0, 1'b1, 1'b1);
		send_word(FN_LOOKUP, 64'h99, 1'b0, 1'b1, 1'b1);
		send_word(FN_REMOVE_W, 64'h77, 1'b0, 1'b1, 1'b1);
		send_word(FN_REMOVE_W, 64'h1234, 1'b0, 1'b1, 1'b0);
		send_word(FN_EVICT, '0, 1'b0, 1'b1, 1'b1);
		send_word(FN_EVICT, '0, 1'b0, 1'b1, 1'b1);
		send_word(FN_STATS, '0, 1'b0, 1'b1, 1'b1);
		send_word(FN_CLEAR, '0, 1'b0, 1'b1, 1'b1);
		send_word(FN_INSERT, 64'h42, 1'b0, 1'b1, 1'b1);
		drain_answers();

		// Random phases, one capacity each; the last one runs without idling.
		foreach (caps[ph]) begin
			write_capacity(5'(caps[ph]));
			quiet = (ph == 11);
			repeat (115) begin
				if ($urandom_range(0, 4) == 0)
					k = {$urandom, $urandom};
				else
					k = key_pool[$urandom_range(0, 23)];
				send_word(pick_func(), k, 1'($urandom_range(0, 1)),
					$urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0);
				if (!quiet && $urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 13));
			end
			drain_answers();
		end

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
